@@ rtl/core/gfp_pkg.sv @@
// Shared constants and types of the gnomonic forward projection block.
// Used by the trig unit, the divider, the top level and the bench.
// No dependencies.
`default_nettype none

package gfp_pkg;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CENTRE_LON = 2'd0;
  localparam cfg_idx_t CFG_CENTRE_LAT = 2'd1;
  localparam cfg_idx_t CFG_PROJ_SCALE = 2'd2;

  localparam logic [31:0] SCALE_RESET = 32'd65536;

  // Angles in units of 1e-7 degree.
  localparam logic [31:0] DEG_EIGHTH  = 32'd450000000;
  localparam logic [31:0] DEG_QUARTER = 32'd900000000;
  localparam logic [31:0] DEG_HALF    = 32'd1800000000;
  localparam logic [31:0] DEG_3QUART  = 32'd2700000000;
  localparam logic signed [33:0] DEG_FULL = 34'sd3600000000;

  // pi / 1.8e9 in Q62, applied as (f * RAD_K) >> 32 to get Q30 radians.
  localparam logic [32:0] RAD_K = 33'd8048910509;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Horner divisors of the sin and cos series.
  localparam int unsigned SIN_DIV [4] = '{72, 42, 20, 6};
  localparam int unsigned COS_DIV [5] = '{90, 56, 30, 12, 2};

  // Pipeline depths and widths of the sub-units.
  localparam int unsigned TRIG_LAT   = 16;
  localparam int unsigned DIV_QBITS  = 47;
  localparam int unsigned DIV_LAT    = DIV_QBITS + 1;
  localparam int unsigned DIV_NUM_W  = 63;
  localparam int unsigned DIV_DEN_W  = 32;

  localparam logic signed [47:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] OUT_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic signed [31:0] sin_v;
    logic signed [31:0] cos_v;
  } trig_t;

endpackage

`default_nettype wire

@@ rtl/core/gfp_in_if.sv @@
// Request channel carrying one geographic point into the projection block.
// Depends on nothing but the field widths of a point.
`default_nettype none

interface gfp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lon_in;
  logic signed [30:0] lat_in;
  logic               last_in;

  modport source (output valid, output lon_in, output lat_in, output last_in, input ready);
  modport sink   (input valid, input lon_in, input lat_in, input last_in, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gfp_out_if.sv @@
// Request channel carrying one projected point out of the projection block.
// Depends on nothing but the field widths of a result.
`default_nettype none

interface gfp_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] x_out;
  logic signed [47:0] y_out;
  logic               beyond_horizon;
  logic               last_out;

  modport source (output valid, output x_out, output y_out, output beyond_horizon,
                  output last_out, input ready);
  modport sink   (input valid, input x_out, input y_out, input beyond_horizon,
                  input last_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gfp_trig.sv @@
// Pipelined sine and cosine of an angle in 1e-7 degree, Q30 results.
// Range reduction, octant fold and Horner series, at most two multipliers per stage.
// Depends on gfp_pkg.
`default_nettype none

module gfp_trig (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [32:0]  angle_i,
  output gfp_pkg::trig_t      trig_o
);
  import gfp_pkg::*;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } hc_t;

  logic signed [33:0] r1_q;
  logic signed [33:0] r2_d;
  logic [31:0]        r2_q;
  logic [1:0]         q3_q;
  logic [29:0]        f3_q;
  logic [1:0]         q4_q;
  logic               swap4_q;
  logic [28:0]        f4_q;
  logic [1:0]         q5_q;
  logic               swap5_q;
  logic [29:0]        x5_q;
  logic [61:0]        rad_prod;
  logic [59:0]        sq_prod;

  hc_t                hc_q [10];
  logic [30:0]        ts_q [5];
  logic [30:0]        tc_q [5];
  logic [29:0]        vs_q [1:4];
  logic [29:0]        vc_q [1:4];

  logic [30:0]        bs;
  logic [30:0]        bc;
  logic signed [31:0] ps;
  logic signed [31:0] pc;
  gfp_pkg::trig_t     trig_d;

  // Two conditional wraps bring any 33-bit angle into one turn.
  always_comb begin
    if (r1_q < 0) begin
      r2_d = r1_q + DEG_FULL;
    end else if (r1_q >= DEG_FULL) begin
      r2_d = r1_q - DEG_FULL;
    end else begin
      r2_d = r1_q;
    end
  end

  assign rad_prod = 62'(f4_q) * 62'(RAD_K);
  assign sq_prod  = 60'(x5_q) * 60'(x5_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q <= (angle_i < 0) ? (34'(angle_i) + DEG_FULL) : 34'(angle_i);
      r2_q <= r2_d[31:0];

      if (r2_q < DEG_QUARTER) begin
        q3_q <= 2'd0;
        f3_q <= 30'(r2_q);
      end else if (r2_q < DEG_HALF) begin
        q3_q <= 2'd1;
        f3_q <= 30'(r2_q - DEG_QUARTER);
      end else if (r2_q < DEG_3QUART) begin
        q3_q <= 2'd2;
        f3_q <= 30'(r2_q - DEG_HALF);
      end else begin
        q3_q <= 2'd3;
        f3_q <= 30'(r2_q - DEG_3QUART);
      end

      q4_q    <= q3_q;
      swap4_q <= (f3_q > 30'(DEG_EIGHTH));
      f4_q    <= (f3_q > 30'(DEG_EIGHTH)) ? 29'(30'(DEG_QUARTER) - f3_q) : 29'(f3_q);

      q5_q    <= q4_q;
      swap5_q <= swap4_q;
      x5_q    <= rad_prod[61:32];

      hc_q[0].x    <= x5_q;
      hc_q[0].x2   <= sq_prod[59:30];
      hc_q[0].quad <= q5_q;
      hc_q[0].swap <= swap5_q;
    end
  end

  // Horner steps past the first are a multiply stage then a divide-by-constant stage.
  for (genvar j = 0; j < 5; j++) begin : g_step
    localparam int unsigned KC = COS_DIV[j];
    localparam int unsigned LC = $clog2(KC);
    localparam logic [31:0] MC = 32'(((64'd1 << (30 + LC)) + 64'(KC) - 64'd1) / 64'(KC));

    logic [29:0] vin_c;
    logic [61:0] dprod_c;

    if (j == 0) begin : g_first
      assign vin_c = hc_q[0].x2;
    end else begin : g_later
      logic [60:0] mprod_s;
      logic [60:0] mprod_c;

      assign vin_c   = vc_q[j];
      assign mprod_c = 61'(hc_q[2*j-1].x2) * 61'(tc_q[j-1]);
      if (j < 4) begin : g_sin_step
        assign mprod_s = 61'(hc_q[2*j-1].x2) * 61'(ts_q[j-1]);
      end else begin : g_sin_final
        assign mprod_s = 61'(hc_q[2*j-1].x) * 61'(ts_q[j-1]);
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          vs_q[j]     <= mprod_s[59:30];
          vc_q[j]     <= mprod_c[59:30];
          hc_q[2*j]   <= hc_q[2*j-1];
        end
      end
    end

    assign dprod_c = 62'(vin_c) * 62'(MC);

    if (j < 4) begin : g_sin_div
      localparam int unsigned KS = SIN_DIV[j];
      localparam int unsigned LS = $clog2(KS);
      localparam logic [31:0] MS = 32'(((64'd1 << (30 + LS)) + 64'(KS) - 64'd1) / 64'(KS));

      logic [29:0] vin_s;
      logic [61:0] dprod_s;

      if (j == 0) begin : g_first_s
        assign vin_s = hc_q[0].x2;
      end else begin : g_later_s
        assign vin_s = vs_q[j];
      end
      assign dprod_s = 62'(vin_s) * 62'(MS);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ts_q[j] <= Q30_ONE - 31'(dprod_s >> (30 + LS));
        end
      end
    end else begin : g_sin_hold
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ts_q[j] <= {1'b0, vs_q[j]};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tc_q[j]     <= Q30_ONE - 31'(dprod_c >> (30 + LC));
        hc_q[2*j+1] <= hc_q[2*j];
      end
    end
  end

  // Above 45 degrees the series ran on the complement, so sin and cos trade places.
  always_comb begin
    bs = hc_q[9].swap ? tc_q[4] : ts_q[4];
    bc = hc_q[9].swap ? ts_q[4] : tc_q[4];
    ps = signed'({1'b0, bs});
    pc = signed'({1'b0, bc});
    case (hc_q[9].quad)
      2'd0: begin
        trig_d.sin_v = ps;
        trig_d.cos_v = pc;
      end
      2'd1: begin
        trig_d.sin_v = pc;
        trig_d.cos_v = -ps;
      end
      2'd2: begin
        trig_d.sin_v = -ps;
        trig_d.cos_v = -pc;
      end
      default: begin
        trig_d.sin_v = -pc;
        trig_d.cos_v = ps;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_o <= trig_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gfp_div.sv @@
// Pipelined restoring divider: floor(num * 256 / den), one quotient bit per stage,
// with an overflow flag when the quotient does not fit its width. Depends on gfp_pkg.
`default_nettype none

module gfp_div (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [gfp_pkg::DIV_NUM_W-1:0]        num_i,
  input  logic [gfp_pkg::DIV_DEN_W-1:0]        den_i,
  output logic [gfp_pkg::DIV_QBITS-1:0]        quo_o,
  output logic                                 ovf_o
);
  import gfp_pkg::*;

  localparam int unsigned PRE    = 8;
  localparam int unsigned HI_LSB = DIV_QBITS - PRE;

  logic [DIV_DEN_W-1:0] rem_q [DIV_QBITS];
  logic [DIV_QBITS-1:0] low_q [DIV_QBITS];
  logic [DIV_DEN_W-1:0] den_q [DIV_QBITS];
  logic [DIV_QBITS-1:0] quo_q [DIV_QBITS+1];
  logic                 ovf_q [DIV_QBITS+1];

  // The quotient overflows exactly when the top part already reaches the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DIV_DEN_W'(num_i[DIV_NUM_W-1:HI_LSB]);
      low_q[0] <= {num_i[HI_LSB-1:0], PRE'(0)};
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (DIV_DEN_W'(num_i[DIV_NUM_W-1:HI_LSB]) >= den_i);
    end
  end

  for (genvar k = 1; k <= DIV_QBITS; k++) begin : g_bit
    logic [DIV_DEN_W:0] rem_sh;
    logic [DIV_DEN_W:0] diff;
    logic               ge;

    assign rem_sh = {rem_q[k-1], low_q[k-1][DIV_QBITS-1]};
    assign diff   = rem_sh - {1'b0, den_q[k-1]};
    assign ge     = (rem_sh >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {quo_q[k-1][DIV_QBITS-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end

    if (k < DIV_QBITS) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
          low_q[k] <= {low_q[k-1][DIV_QBITS-2:0], 1'b0};
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign quo_o = quo_q[DIV_QBITS];
  assign ovf_o = ovf_q[DIV_QBITS];

endmodule

`default_nettype wire

@@ rtl/core/gnomonic_forward_projection.sv @@
// Gnomonic forward projection of geographic points about a configured centre.
// Depends on gfp_pkg, gfp_in_if, gfp_out_if, gfp_trig and gfp_div.
//
// Usage:
//   point_i carries requests of (lon_in, lat_in, last_in); proj_o returns one
//   request per point with x_out, y_out (signed Q24.24), beyond_horizon and
//   last_out, in input order.
//   The configuration port writes centre_lon (index 0), centre_lat (index 1)
//   and proj_scale (index 2) on a cycle with cfg_we_i high; other indexes are
//   ignored. Write only while no point is in flight.
//   One point is accepted every cycle unless the output stalls: the trig units
//   are 16 stages of at most two multipliers each and the divider has 48 stages,
//   an overflow check and then one quotient bit per stage.
//   The whole pipeline advances together; when the result register holds an
//   unaccepted request and proj_o.ready is low, every stage holds and
//   point_i.ready drops, so nothing is lost or repeated.
//   Reset clears all valid bits and sets the centre to (0, 0) and the scale
//   to 1.0. There is no clearing pass; a point may be sent right after reset.
`default_nettype none

module gnomonic_forward_projection (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  gfp_pkg::cfg_idx_t cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  gfp_in_if.sink            point_i,
  gfp_out_if.source         proj_o
);
  import gfp_pkg::*;

  localparam int unsigned PIPE_LAT = 1 + TRIG_LAT + 5 + DIV_LAT + 1;

  logic signed [31:0] lon0_q;
  logic signed [30:0] lat0_q;
  logic [31:0]        scale_q;

  logic                en;
  logic [PIPE_LAT-1:0] vld_q;
  logic [PIPE_LAT-1:0] last_q;

  logic signed [32:0] dlon_q;
  logic signed [32:0] lat_q;
  logic signed [32:0] clat_q;

  trig_t tlat;
  trig_t tcen;
  trig_t tdlon;

  logic signed [63:0] ccdp_q;
  logic signed [63:0] nx1_q;
  logic signed [63:0] p1_q;
  logic signed [63:0] p2_q;
  logic signed [31:0] s0_q;
  logic signed [31:0] c0_q;

  logic signed [31:0] ccd;
  logic signed [63:0] p3_q;
  logic signed [63:0] p4_q;
  logic signed [63:0] p1b_q;
  logic signed [63:0] p2b_q;
  logic signed [63:0] nx2_q;

  logic signed [63:0] d60_q;
  logic signed [63:0] ny3_q;
  logic signed [63:0] nx3_q;

  logic signed [33:0] d30;
  logic signed [32:0] nx30;
  logic signed [32:0] ny30;
  logic signed [32:0] nx30_abs;
  logic signed [32:0] ny30_abs;
  logic               hor;
  logic [31:0]        magx_q;
  logic [31:0]        magy_q;
  logic               negx4_q;
  logic               negy4_q;
  logic               hor4_q;
  logic [31:0]        den4_q;

  logic [DIV_NUM_W-1:0] numx5_q;
  logic [DIV_NUM_W-1:0] numy5_q;
  logic [31:0]          den5_q;
  logic [2:0]           side5_q;

  logic [2:0]           side_q [DIV_LAT];
  logic [DIV_QBITS-1:0] quox;
  logic [DIV_QBITS-1:0] quoy;
  logic                 ovfx;
  logic                 ovfy;

  logic               negx;
  logic               negy;
  logic               hor_f;
  logic               satx;
  logic               saty;
  logic signed [47:0] x_d;
  logic signed [47:0] y_d;

  logic signed [47:0] x_q;
  logic signed [47:0] y_q;
  logic               bh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lon0_q  <= '0;
      lat0_q  <= '0;
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTRE_LON: lon0_q  <= signed'(cfg_data_i);
        CFG_CENTRE_LAT: lat0_q  <= signed'(cfg_data_i[30:0]);
        CFG_PROJ_SCALE: scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // All stages move together unless a finished result waits at the output.
  assign en            = ~vld_q[PIPE_LAT-1] | proj_o.ready;
  assign point_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], point_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q <= {last_q[PIPE_LAT-2:0], point_i.last_in};
      dlon_q <= 33'(point_i.lon_in) - 33'(lon0_q);
      lat_q  <= 33'(point_i.lat_in);
      clat_q <= 33'(lat0_q);
    end
  end

  gfp_trig u_trig_lat (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (lat_q),
    .trig_o  (tlat)
  );

  gfp_trig u_trig_cen (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (clat_q),
    .trig_o  (tcen)
  );

  gfp_trig u_trig_dlon (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (dlon_q),
    .trig_o  (tdlon)
  );

  // Products of Q30 terms are Q60; cos(lat)cos(dlon) is floored back to Q30.
  assign ccd = 32'(ccdp_q >>> 30);

  always_comb begin
    d30      = 34'(d60_q >>> 30);
    nx30     = 33'(nx3_q >>> 30);
    ny30     = 33'(ny3_q >>> 30);
    nx30_abs = (nx30 < 0) ? -nx30 : nx30;
    ny30_abs = (ny30 < 0) ? -ny30 : ny30;
    hor      = (d30 <= 0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ccdp_q <= 64'(tlat.cos_v) * 64'(tdlon.cos_v);
      nx1_q  <= 64'(tlat.cos_v) * 64'(tdlon.sin_v);
      p1_q   <= 64'(tcen.sin_v) * 64'(tlat.sin_v);
      p2_q   <= 64'(tcen.cos_v) * 64'(tlat.sin_v);
      s0_q   <= tcen.sin_v;
      c0_q   <= tcen.cos_v;

      p3_q  <= 64'(c0_q) * 64'(ccd);
      p4_q  <= 64'(s0_q) * 64'(ccd);
      p1b_q <= p1_q;
      p2b_q <= p2_q;
      nx2_q <= nx1_q;

      d60_q <= p1b_q + p3_q;
      ny3_q <= p2b_q - p4_q;
      nx3_q <= nx2_q;

      magx_q  <= nx30_abs[31:0];
      magy_q  <= ny30_abs[31:0];
      negx4_q <= (nx30 < 0);
      negy4_q <= (ny30 < 0);
      hor4_q  <= hor;
      den4_q  <= hor ? 32'd1 : d30[31:0];

      numx5_q <= DIV_NUM_W'(magx_q) * DIV_NUM_W'(scale_q);
      numy5_q <= DIV_NUM_W'(magy_q) * DIV_NUM_W'(scale_q);
      den5_q  <= den4_q;
      side5_q <= {hor4_q, negy4_q, negx4_q};
    end
  end

  gfp_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numx5_q),
    .den_i (den5_q),
    .quo_o (quox),
    .ovf_o (ovfx)
  );

  gfp_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numy5_q),
    .den_i (den5_q),
    .quo_o (quoy),
    .ovf_o (ovfy)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side5_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Horizon and overflow saturate toward the sign of the numerator.
  always_comb begin
    negx  = side_q[DIV_LAT-1][0];
    negy  = side_q[DIV_LAT-1][1];
    hor_f = side_q[DIV_LAT-1][2];
    satx  = hor_f | ovfx;
    saty  = hor_f | ovfy;
    if (satx) begin
      x_d = negx ? OUT_MIN : OUT_MAX;
    end else begin
      x_d = negx ? -signed'(48'(quox)) : signed'(48'(quox));
    end
    if (saty) begin
      y_d = negy ? OUT_MIN : OUT_MAX;
    end else begin
      y_d = negy ? -signed'(48'(quoy)) : signed'(48'(quoy));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q  <= x_d;
      y_q  <= y_d;
      bh_q <= satx | saty;
    end
  end

  assign proj_o.valid          = vld_q[PIPE_LAT-1];
  assign proj_o.x_out          = x_q;
  assign proj_o.y_out          = y_q;
  assign proj_o.beyond_horizon = bh_q;
  assign proj_o.last_out       = last_q[PIPE_LAT-1];

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the gnomonic forward projection block.
// Depends on gfp_pkg, gfp_in_if, gfp_out_if and gnomonic_forward_projection.
// A fixed-point predictor works out each untyped request; results are checked in order.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gfp_pkg::*;

  localparam cfg_idx_t CFG_UNUSED = 2'd3;
  localparam int unsigned PIPE_LAT = 71;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned N_RANDOM = 1730;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint QUOT_LIMIT = 64'sd1 << 39;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic               horizon;
    logic               last;
  } proj_t;

  typedef struct packed {
    logic signed [31:0] lon;
    logic signed [30:0] lat;
    logic               last;
    logic               typed;
    proj_t              res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  cfg_idx_t cfg_idx_i;
  logic [31:0] cfg_data_i;

  gfp_in_if  pt ();
  gfp_out_if pr ();

  gnomonic_forward_projection u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .point_i   (pt.sink),
    .proj_o    (pr.source)
  );

  always #5 clk_i = ~clk_i;

  // Copies of the block's registers.
  logic signed [31:0] ctr_lon;
  logic signed [30:0] ctr_lat;
  logic [31:0]        scale_q16;

  proj_t pending_q[$];
  row_t  override_q[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_horizon = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;

  function automatic longint floor_shr30(longint v);
    return v >>> 30;
  endfunction

  // Series sin and cos of a folded angle in [0, 45] degrees, Q30.
  function automatic void series_trig(longint f, output longint s, output longint c);
    longint unsigned x, x2, t;
    x  = (longint'(f) * 64'd8048910509) >> 32;
    x2 = (x * x) >> 30;
    t = ONE_Q30 - x2 / 72;
    t = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s = longint'((x * t) >> 30);
    t = ONE_Q30 - x2 / 90;
    t = ONE_Q30 - ((x2 * t) >> 30) / 56;
    t = ONE_Q30 - ((x2 * t) >> 30) / 30;
    t = ONE_Q30 - ((x2 * t) >> 30) / 12;
    t = ONE_Q30 - ((x2 * t) >> 30) / 2;
    c = longint'(t);
  endfunction

  function automatic void angle_trig(longint a, output longint s, output longint c);
    longint r, q, f, bs, bc;
    r = a % 64'sd3600000000;
    if (r < 0) r += 64'sd3600000000;
    q = r / 64'sd900000000;
    f = r - q * 64'sd900000000;
    if (f > 64'sd450000000) series_trig(64'sd900000000 - f, bc, bs);
    else series_trig(f, bs, bc);
    case (q)
      0: begin s = bs;  c = bc;  end
      1: begin s = bc;  c = -bs; end
      2: begin s = -bs; c = -bc; end
      default: begin s = -bc; c = bs; end
    endcase
  endfunction

  function automatic logic signed [47:0] scale_divide(longint num60, longint den30,
                                                      inout logic sat);
    longint n30;
    longint unsigned mag, n, q, r, m;
    logic neg;
    n30 = floor_shr30(num60);
    neg = n30 < 0;
    mag = neg ? longint'(-n30) : longint'(n30);
    if (den30 <= 0) begin
      sat = 1'b1;
      return neg ? OUT_MIN : OUT_MAX;
    end
    n = mag * longint'(scale_q16);
    q = n / longint'(den30);
    r = n % longint'(den30);
    if (q >= QUOT_LIMIT) begin
      sat = 1'b1;
      return neg ? OUT_MIN : OUT_MAX;
    end
    m = q * 256 + (r * 256) / longint'(den30);
    return 48'(neg ? -longint'(m) : longint'(m));
  endfunction

  function automatic proj_t project_point(logic signed [31:0] lon, logic signed [30:0] lat,
                                          logic last);
    longint sl, cl, s0, c0, sd, cd, ccd, d30;
    logic sat;
    proj_t p;
    sat = 1'b0;
    angle_trig(longint'(lat), sl, cl);
    angle_trig(longint'(ctr_lat), s0, c0);
    angle_trig(longint'(lon) - longint'(ctr_lon), sd, cd);
    ccd = floor_shr30(cl * cd);
    d30 = floor_shr30(s0 * sl + c0 * ccd);
    p.x = scale_divide(cl * sd, d30, sat);
    p.y = scale_divide(c0 * sl - s0 * ccd, d30, sat);
    p.horizon = sat;
    p.last = last;
    return p;
  endfunction

  // Prediction at every accepted point request.
  always @(posedge clk_i) begin
    row_t o;
    if (pt.valid && pt.ready) begin
      o = override_q.pop_front();
      pending_q.insert(pending_q.size(),
                       o.typed ? o.res : project_point(pt.lon_in, pt.lat_in, pt.last_in));
    end
  end

  // Result check.
  always @(posedge clk_i) begin
    proj_t e;
    if (pr.valid && pr.ready) begin
      if (pending_q.size() == 0) begin
        $error("result request with nothing expected");
        errors++;
      end else begin
        e = pending_q.pop_front();
        n_checked++;
        if (pr.beyond_horizon) n_horizon++;
        if (pr.x_out !== e.x) begin
          $error("x_out expected %0d actual %0d", e.x, pr.x_out); errors++;
        end
        if (pr.y_out !== e.y) begin
          $error("y_out expected %0d actual %0d", e.y, pr.y_out); errors++;
        end
        if (pr.beyond_horizon !== e.horizon) begin
          $error("beyond_horizon expected %0b actual %0b", e.horizon, pr.beyond_horizon);
          errors++;
        end
        if (pr.last_out !== e.last) begin
          $error("last_out expected %0b actual %0b", e.last, pr.last_out); errors++;
        end
      end
    end
  end

  // Receiver stalls in random bursts, and starts none once quiet is set.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 4);
    if (stall_left > 0) begin
      pr.ready <= 1'b0;
      stall_left--;
    end else begin
      pr.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run timed out with %0d results outstanding", pending_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic cfg_write(cfg_idx_t idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_CENTRE_LON: ctr_lon = data;
      CFG_CENTRE_LAT: ctr_lat = data[30:0];
      CFG_PROJ_SCALE: scale_q16 = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_point(row_t r);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      pt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    override_q.insert(override_q.size(), r);
    pt.valid   <= 1'b1;
    pt.lon_in  <= r.lon;
    pt.lat_in  <= r.lat;
    pt.last_in <= r.last;
    do @(posedge clk_i); while (!pt.ready);
    n_sent++;
  endtask

  // Called right at the edge that accepted the last point.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    pt.valid <= 1'b0;
    while (pending_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    // Let the pipeline settle before the next register write.
    repeat (PIPE_LAT + 8) @(posedge clk_i);
  endtask

  function automatic row_t random_point();
    row_t r;
    int k;
    r = '0;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      // Near the centre, so most points stay on the visible side.
      r.lon = ctr_lon + $signed($urandom_range(0, 600000000)) - 300000000;
      r.lat = 31'($signed(32'(ctr_lat)) + $signed($urandom_range(0, 600000000)) - 300000000);
    end else if (k < 9) begin
      r.lon = 32'($signed($urandom_range(0, 3600000000)) - 64'sd1800000000);
      r.lat = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
    end else begin
      r.lon = $urandom();
      r.lat = 31'($urandom());
    end
    r.last = 1'($urandom_range(0, 1));
    return r;
  endfunction

  row_t dir_tbl[$];

  function automatic void add_row(row_t r);
    dir_tbl.insert(dir_tbl.size(), r);
  endfunction

  initial begin
    row_t r;
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_CENTRE_LON;
    cfg_data_i <= '0;
    pt.valid <= 1'b0;
    pt.lon_in <= '0;
    pt.lat_in <= '0;
    pt.last_in <= 1'b0;
    ctr_lon = '0;
    ctr_lat = '0;
    scale_q16 = SCALE_RESET;

    // Directed rows; typed results for the reset centre.
    add_row('{32'sd0, 31'sd0, 1'b0, 1'b1, '{48'sd0, 48'sd0, 1'b0, 1'b0}});
    add_row('{32'sd900000000, 31'sd0, 1'b1, 1'b1, '{OUT_MAX, OUT_MAX, 1'b1, 1'b1}});
    add_row('{32'sd1800000000, 31'sd0, 1'b0, 1'b1, '{OUT_MAX, OUT_MAX, 1'b1, 1'b0}});
    add_row('{-32'sd1800000000, 31'sd0, 1'b1, 1'b0, '0});
    add_row('{32'sd0, 31'sd900000000, 1'b0, 1'b0, '0});
    add_row('{32'sd0, -31'sd900000000, 1'b1, 1'b0, '0});
    add_row('{-32'sd900000000, 31'sd0, 1'b0, 1'b0, '0});
    add_row('{32'sd100000000, 31'sd200000000, 1'b0, 1'b0, '0});
    add_row('{-32'sd300000000, -31'sd400000000, 1'b1, 1'b0, '0});
    add_row('{32'sd450000000, 31'sd450000000, 1'b0, 1'b0, '0});
    add_row('{32'sd899999999, 31'sd1, 1'b0, 1'b0, '0});
    add_row('{32'h7FFF_FFFF, 31'h3FFF_FFFF, 1'b1, 1'b0, '0});
    add_row('{32'h8000_0000, 31'h4000_0000, 1'b0, 1'b0, '0});
    add_row('{32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0, '0});
    add_row('{32'sd1, -31'sd1, 1'b0, 1'b0, '0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) send_point(dir_tbl[i]);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          cfg_write(CFG_CENTRE_LON, 32'sd1800000000);
          cfg_write(CFG_CENTRE_LAT, 32'sd900000000);
          cfg_write(CFG_PROJ_SCALE, 32'd0);
        end
        1: begin
          cfg_write(CFG_CENTRE_LON, -32'sd1800000000);
          cfg_write(CFG_CENTRE_LAT, -32'sd900000000);
          cfg_write(CFG_PROJ_SCALE, 32'hFFFF_FFFF);
        end
        2: begin
          cfg_write(CFG_CENTRE_LON, $urandom());
          cfg_write(CFG_CENTRE_LAT, $urandom());
          cfg_write(CFG_PROJ_SCALE, $urandom());
          // Writes to the unused index must leave the registers alone.
          cfg_write(CFG_UNUSED, $urandom());
        end
        default: begin
          cfg_write(CFG_CENTRE_LON,
                    32'($signed($urandom_range(0, 3600000000)) - 64'sd1800000000));
          cfg_write(CFG_CENTRE_LAT, $signed($urandom_range(0, 1800000000)) - 900000000);
          cfg_write(CFG_PROJ_SCALE, $urandom_range(0, 5) == 0 ? $urandom()
                                                           : $urandom_range(1, 1 << 22));
        end
      endcase
      for (int i = 0; i < N_RANDOM / 7; i++) begin
        if (ph == 6 && i > N_RANDOM / 14) quiet = 1'b1;
        r = random_point();
        send_point(r);
      end
      drain();
    end

    $display("sent %0d points, checked %0d projected points (%0d flagged)", n_sent,
             n_checked, n_horizon);
    $display("over %0d centre and scale settings", 8);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
